>>> design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam logic [2:0] OP_INSERT   = 3'd0;
  localparam logic [2:0] OP_POP      = 3'd1;
  localparam logic [2:0] OP_DEL_PRI  = 3'd2;
  localparam logic [2:0] OP_DEL_BOTH = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPACT,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] data;
    logic [7:0]  prio;
  } entry_t;

  typedef struct packed {
    logic        insert;
    logic        pop;
    logic        mark;
    logic        match_data;
    logic        clear;
    logic        compact;
    logic [31:0] data;
    logic [7:0]  prio;
  } cell_cmd_t;

endpackage

>>> design/spq_cmd_if.sv
// Command channel interface of the sorted priority queue.
interface spq_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] data_value;
  logic [7:0]         priority_value;

  modport source (output valid, opcode, data_value, priority_value, input ready);
  modport sink (input valid, opcode, data_value, priority_value, output ready);
endinterface

>>> design/spq_rsp_if.sv
// Response channel interface of the sorted priority queue.
interface spq_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [4:0]         removed_count;
  logic [4:0]         occupancy;
  logic               head_valid;
  logic signed [31:0] head_data;
  logic [7:0]         head_priority;

  modport source (output valid, status, removed_count, occupancy, head_valid, head_data,
                  head_priority, input ready);
  modport sink (input valid, status, removed_count, occupancy, head_valid, head_data,
                head_priority, output ready);
endinterface

>>> design/sorted_priority_queue.sv
// Top level of the sorted priority queue: command decode, control and the chain of slots.
//
//   channel  direction  contents
//   cmd      sink       opcode, data_value, priority_value
//   rsp      source     status, removed_count, occupancy, head entry
//
// Insert, pop and clear update the chain as the command is accepted; the response loads from ST_REPORT.
// Deletes mark the matching entries on accept, then close the gaps one at a time in ST_COMPACT,
// leave it once the chain is seen closed and load the response from ST_REPORT.
// A new command is taken in the cycle the response register loads, so commands overlap.
// Reset empties every slot at once; a stalled response holds off any command in ST_REPORT.
module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  spq_cmd_if.sink   cmd,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   base_count, base_count_next;
  logic [1:0]      status_q, status_next;
  logic            rm_op, rm_op_next;
  cell_cmd_t       cc;
  entry_t          cell_q [DEPTH];
  entry_t          next_q [DEPTH];
  entry_t          prev_q [DEPTH];
  logic [DEPTH:0]  ins_chain;
  logic [DEPTH:0]  hole_chain;
  logic            accept;
  logic            out_free;
  logic            load_out;
  logic            empty;
  logic            full;
  logic [CW-1:0]   removed;
  logic [CW+4:0]   removed_ext;
  logic [CW+4:0]   count_ext;

  assign out_free  = !rsp.valid || rsp.ready;
  assign cmd.ready = (state == ST_IDLE) || ((state == ST_REPORT) && out_free);
  assign accept    = cmd.valid && cmd.ready;
  assign load_out  = (state == ST_REPORT) && out_free;
  assign empty     = (count == '0);
  assign full      = (count == CW'(DEPTH));

  assign ins_chain[0]  = 1'b0;
  assign hole_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_q[i] = '0;
    end else begin : g_mid
      assign prev_q[i] = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_q[i] = '0;
    end else begin : g_rest
      assign next_q[i] = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cc),
      .in_range   (CW'(i) < count),
      .prev_entry (prev_q[i]),
      .next_entry (next_q[i]),
      .ins_in     (ins_chain[i]),
      .ins_out    (ins_chain[i+1]),
      .hole_in    (hole_chain[i]),
      .hole_out   (hole_chain[i+1]),
      .entry      (cell_q[i])
    );
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    base_count_next = base_count;
    status_next     = status_q;
    rm_op_next      = rm_op;
    cc              = '0;
    cc.data         = cmd.data_value;
    cc.prio         = cmd.priority_value;
    case (state)
      ST_COMPACT: begin
        if (hole_chain[DEPTH]) begin
          cc.compact = 1'b1;
          count_next = count - CW'(1);
        end else begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
      end
    endcase
    if (accept) begin
      state_next      = ST_REPORT;
      base_count_next = count;
      status_next     = STAT_OK;
      rm_op_next      = 1'b0;
      case (cmd.opcode)
        OP_INSERT: begin
          if (full) begin
            status_next = STAT_FULL;
          end else begin
            cc.insert  = 1'b1;
            count_next = count + CW'(1);
          end
        end
        OP_POP, OP_DEL_PRI, OP_DEL_BOTH, OP_CLEAR: begin
          rm_op_next = 1'b1;
          if (empty) begin
            status_next = STAT_EMPTY;
          end else if (cmd.opcode == OP_POP) begin
            cc.pop     = 1'b1;
            count_next = count - CW'(1);
          end else if (cmd.opcode == OP_CLEAR) begin
            cc.clear   = 1'b1;
            count_next = '0;
          end else begin
            cc.mark       = 1'b1;
            cc.match_data = (cmd.opcode == OP_DEL_BOTH);
            state_next    = ST_COMPACT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    base_count <= base_count_next;
    status_q   <= status_next;
    rm_op      <= rm_op_next;
  end

  assign removed     = rm_op ? (base_count - count) : '0;
  assign removed_ext = {5'd0, removed};
  assign count_ext   = {5'd0, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.status        <= status_q;
      rsp.removed_count <= removed_ext[4:0];
      rsp.occupancy     <= count_ext[4:0];
      rsp.head_valid    <= !empty;
      rsp.head_data     <= empty ? 32'sd0 : signed'(cell_q[0].data);
      rsp.head_priority <= empty ? 8'd0 : cell_q[0].prio;
    end
  end
endmodule

>>> design/spq_cell.sv
// One slot of the queue with its insert, shift, match and compaction logic.
module spq_cell (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic               in_range,
  input  spq_pkg::entry_t    prev_entry,
  input  spq_pkg::entry_t    next_entry,
  input  logic               ins_in,
  output logic               ins_out,
  input  logic               hole_in,
  output logic               hole_out,
  output spq_pkg::entry_t    entry
);
  import spq_pkg::*;

  entry_t entry_next;
  logic   ins_here;
  logic   hit;

  assign ins_here = !entry.valid || (entry.prio > cmd.prio);
  assign ins_out  = ins_in || ins_here;
  assign hole_out = hole_in || (!entry.valid && in_range);
  assign hit      = entry.valid && (entry.prio == cmd.prio) &&
                    (!cmd.match_data || (entry.data == cmd.data));

  always_comb begin
    entry_next = entry;
    if (cmd.clear) begin
      entry_next.valid = 1'b0;
    end else if (cmd.insert) begin
      if (ins_in) begin
        entry_next = prev_entry;
      end else if (ins_here) begin
        entry_next = '{valid: 1'b1, data: cmd.data, prio: cmd.prio};
      end
    end else if (cmd.pop) begin
      entry_next = next_entry;
    end else if (cmd.mark) begin
      if (hit) begin
        entry_next.valid = 1'b0;
      end
    end else if (cmd.compact && hole_out) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry.data <= entry_next.data;
    entry.prio <= entry_next.prio;
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
  end
endmodule
